// ----- rtl/core/ctle_pkg.sv -----
// Shared types, constants and codes of the canonical tty line editor.
`default_nettype none

package ctle_pkg;

   // Line store geometry.
   localparam int LINE_DEPTH = 16;
   localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
   localparam int IDX_W      = $clog2(LINE_DEPTH);

   // Configuration port geometry.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int MODE_W     = 6;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERRUPT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_QUIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SUSPEND   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ERASE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KILL      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_EOF       = 3'd6;

   // Bit positions in the mode register.
   localparam int FLAG_CRNL  = 0;
   localparam int FLAG_SIG   = 1;
   localparam int FLAG_CANON = 2;
   localparam int FLAG_ECHO  = 3;
   localparam int FLAG_ECHOE = 4;
   localparam int FLAG_ONLCR = 5;

   // Reset values of the configuration registers.
   localparam logic [MODE_W-1:0] RESET_MODE      = 6'd63;
   localparam logic [7:0]        RESET_INTERRUPT = 8'd3;
   localparam logic [7:0]        RESET_QUIT      = 8'd28;
   localparam logic [7:0]        RESET_SUSPEND   = 8'd26;
   localparam logic [7:0]        RESET_ERASE     = 8'd127;
   localparam logic [7:0]        RESET_KILL      = 8'd21;
   localparam logic [7:0]        RESET_EOF       = 8'd4;

   // Character constants.
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_C      = 8'h43;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_Z      = 8'h5A;
   localparam logic [7:0] CHAR_BS     = 8'h08;
   localparam logic [7:0] CHAR_SP     = 8'h20;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   // Signal codes.
   localparam logic [1:0] SIG_INTERRUPT = 2'd0;
   localparam logic [1:0] SIG_QUIT      = 2'd1;
   localparam logic [1:0] SIG_SUSPEND   = 2'd2;

   typedef enum logic [2:0] {
      KIND_ECHO    = 3'd0,
      KIND_DELIVER = 3'd1,
      KIND_SIGNAL  = 3'd2,
      KIND_EOF     = 3'd3,
      KIND_FLUSH   = 3'd4,
      KIND_REJECT  = 3'd5
   } result_kind_type;

   // Source of the byte field of a result word.
   typedef enum logic [3:0] {
      BSEL_ZERO,
      BSEL_DATA,
      BSEL_STORE,
      BSEL_CARET,
      BSEL_LETTER,
      BSEL_CR,
      BSEL_LF,
      BSEL_BS,
      BSEL_SP
   } byte_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REJECT,
      ST_SIGNAL,
      ST_FLUSH,
      ST_CARET,
      ST_LETTER,
      ST_SIG_CR,
      ST_SIG_LF,
      ST_RAW,
      ST_ECHO_CR,
      ST_ECHO_BYTE,
      ST_BS1,
      ST_SP,
      ST_BS2,
      ST_EOF,
      ST_RELEASE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load;
      logic            set_abort;
      logic            end_item;
      logic            clear_len;
      logic            dec_len;
      logic            store_byte;
      logic            idx_clear;
      logic            idx_inc;
      logic            emit;
      result_kind_type kind;
      byte_sel_type    bsel;
      logic            last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic aborted;
      logic is_sig;
      logic canon;
      logic echo;
      logic echoe;
      logic onlcr;
      logic is_erase;
      logic is_kill;
      logic is_eof;
      logic is_lf;
      logic full;
      logic len_zero;
      logic rel_last;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/ctle_channels.sv -----
// Valid/ready channel interfaces for typed bytes and result words.
`default_nettype none

interface ctle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_of_write;

   modport source (output valid, output data_byte, output last_of_write, input ready);
   modport sink (input valid, input data_byte, input last_of_write, output ready);
endinterface

interface ctle_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [7:0] result_byte;
   logic [1:0] signal_kind;
   logic       last_result;

   modport source (output valid, output result_kind, output result_byte,
                   output signal_kind, output last_result, input ready);
   modport sink (input valid, input result_kind, input result_byte,
                 input signal_kind, input last_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ctle_ctl.sv -----
// Controller state machine that sequences the result words of one typed byte.
`default_nettype none

module ctle_ctl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ctle_pkg::status_type  status,
   output ctle_pkg::cmd_type     cmd
);

   ctle_pkg::state_type state_ff, state_in;
   logic                kill_ff, kill_in;
   logic                fr;

   assign fr = status.out_free;

   // Next state and the kill-run flag.
   always_comb begin
      state_in = state_ff;
      kill_in  = kill_ff;
      case (state_ff)
         ctle_pkg::ST_IDLE: begin
            if (in_valid) state_in = ctle_pkg::ST_DECODE;
         end
         ctle_pkg::ST_DECODE: begin
            if (status.aborted) begin
               state_in = ctle_pkg::ST_REJECT;
            end else if (status.is_sig) begin
               state_in = ctle_pkg::ST_SIGNAL;
            end else if (!status.canon) begin
               state_in = ctle_pkg::ST_RAW;
            end else if (status.is_erase || status.is_kill) begin
               // Erase wins when the same byte is both erase and kill.
               kill_in = status.is_kill && !status.is_erase;
               if (!status.len_zero && status.echo && status.echoe)
                  state_in = ctle_pkg::ST_BS1;
               else
                  state_in = ctle_pkg::ST_FINISH;
            end else if (status.is_eof) begin
               state_in = status.len_zero ? ctle_pkg::ST_EOF : ctle_pkg::ST_RELEASE;
            end else if (status.full) begin
               state_in = ctle_pkg::ST_REJECT;
            end else if (status.echo) begin
               state_in = (status.is_lf && status.onlcr) ? ctle_pkg::ST_ECHO_CR
                                                         : ctle_pkg::ST_ECHO_BYTE;
            end else begin
               state_in = status.is_lf ? ctle_pkg::ST_RELEASE : ctle_pkg::ST_FINISH;
            end
         end
         ctle_pkg::ST_REJECT:  if (fr) state_in = ctle_pkg::ST_FINISH;
         ctle_pkg::ST_SIGNAL:  if (fr) state_in = ctle_pkg::ST_FLUSH;
         ctle_pkg::ST_FLUSH: begin
            if (fr) state_in = status.echo ? ctle_pkg::ST_CARET : ctle_pkg::ST_FINISH;
         end
         ctle_pkg::ST_CARET:   if (fr) state_in = ctle_pkg::ST_LETTER;
         ctle_pkg::ST_LETTER:  if (fr) state_in = ctle_pkg::ST_SIG_CR;
         ctle_pkg::ST_SIG_CR:  if (fr) state_in = ctle_pkg::ST_SIG_LF;
         ctle_pkg::ST_SIG_LF:  if (fr) state_in = ctle_pkg::ST_FINISH;
         ctle_pkg::ST_RAW: begin
            if (fr) begin
               if (!status.echo)
                  state_in = ctle_pkg::ST_FINISH;
               else if (status.is_lf && status.onlcr)
                  state_in = ctle_pkg::ST_ECHO_CR;
               else
                  state_in = ctle_pkg::ST_ECHO_BYTE;
            end
         end
         ctle_pkg::ST_ECHO_CR: if (fr) state_in = ctle_pkg::ST_ECHO_BYTE;
         ctle_pkg::ST_ECHO_BYTE: begin
            if (fr) begin
               state_in = (status.canon && status.is_lf) ? ctle_pkg::ST_RELEASE
                                                         : ctle_pkg::ST_FINISH;
            end
         end
         ctle_pkg::ST_BS1:     if (fr) state_in = ctle_pkg::ST_SP;
         ctle_pkg::ST_SP:      if (fr) state_in = ctle_pkg::ST_BS2;
         ctle_pkg::ST_BS2: begin
            if (fr) begin
               state_in = (kill_ff && !status.len_zero) ? ctle_pkg::ST_BS1
                                                       : ctle_pkg::ST_FINISH;
            end
         end
         ctle_pkg::ST_EOF:     if (fr) state_in = ctle_pkg::ST_FINISH;
         ctle_pkg::ST_RELEASE: begin
            if (fr && status.rel_last) state_in = ctle_pkg::ST_FINISH;
         end
         ctle_pkg::ST_FINISH:  state_in = ctle_pkg::ST_IDLE;
         default:              state_in = ctle_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath for the current state.
   always_comb begin
      cmd      = '0;
      cmd.kind = ctle_pkg::KIND_ECHO;
      cmd.bsel = ctle_pkg::BSEL_ZERO;
      in_ready = 1'b0;
      case (state_ff)
         ctle_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ctle_pkg::ST_DECODE: begin
            if (status.aborted) begin
               cmd.set_abort = 1'b0;
            end else if (status.is_sig) begin
               cmd.clear_len = 1'b1;
            end else if (!status.canon) begin
               cmd.set_abort = 1'b0;
            end else if (status.is_erase) begin
               cmd.dec_len = !status.len_zero;
            end else if (status.is_kill) begin
               if (status.echo && status.echoe)
                  cmd.dec_len = !status.len_zero;
               else
                  cmd.clear_len = 1'b1;
            end else if (status.is_eof) begin
               cmd.idx_clear = 1'b1;
            end else if (status.full) begin
               cmd.set_abort = 1'b1;
            end else begin
               cmd.store_byte = 1'b1;
               cmd.idx_clear  = 1'b1;
            end
         end
         ctle_pkg::ST_REJECT: begin
            cmd.emit = fr;
            cmd.kind = ctle_pkg::KIND_REJECT;
            cmd.last = 1'b1;
         end
         ctle_pkg::ST_SIGNAL: begin
            cmd.emit = fr;
            cmd.kind = ctle_pkg::KIND_SIGNAL;
         end
         ctle_pkg::ST_FLUSH: begin
            cmd.emit = fr;
            cmd.kind = ctle_pkg::KIND_FLUSH;
            cmd.last = !status.echo;
         end
         ctle_pkg::ST_CARET: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_CARET;
         end
         ctle_pkg::ST_LETTER: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_LETTER;
         end
         ctle_pkg::ST_SIG_CR: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_CR;
         end
         ctle_pkg::ST_SIG_LF: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_LF;
            cmd.last = 1'b1;
         end
         ctle_pkg::ST_RAW: begin
            cmd.emit = fr;
            cmd.kind = ctle_pkg::KIND_DELIVER;
            cmd.bsel = ctle_pkg::BSEL_DATA;
            cmd.last = !status.echo;
         end
         ctle_pkg::ST_ECHO_CR: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_CR;
         end
         ctle_pkg::ST_ECHO_BYTE: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_DATA;
            cmd.last = !(status.canon && status.is_lf);
         end
         ctle_pkg::ST_BS1: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_BS;
         end
         ctle_pkg::ST_SP: begin
            cmd.emit = fr;
            cmd.bsel = ctle_pkg::BSEL_SP;
         end
         ctle_pkg::ST_BS2: begin
            cmd.emit    = fr;
            cmd.bsel    = ctle_pkg::BSEL_BS;
            cmd.last    = !kill_ff || status.len_zero;
            cmd.dec_len = fr && kill_ff && !status.len_zero;
         end
         ctle_pkg::ST_EOF: begin
            cmd.emit = fr;
            cmd.kind = ctle_pkg::KIND_EOF;
            cmd.last = 1'b1;
         end
         ctle_pkg::ST_RELEASE: begin
            cmd.emit      = fr;
            cmd.kind      = ctle_pkg::KIND_DELIVER;
            cmd.bsel      = ctle_pkg::BSEL_STORE;
            cmd.last      = status.rel_last;
            cmd.idx_inc   = fr;
            cmd.clear_len = fr && status.rel_last;
         end
         ctle_pkg::ST_FINISH: begin
            cmd.end_item = 1'b1;
         end
         default: begin
            cmd.end_item = 1'b0;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctle_pkg::ST_IDLE;
         kill_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         kill_ff  <= kill_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ctle_dp.sv -----
// Datapath: configuration, line store, length and index counters, result register.
`default_nettype none

module ctle_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ctle_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ctle_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [7:0]                           in_byte,
   input  logic                                 in_last,
   input  ctle_pkg::cmd_type                    cmd,
   output ctle_pkg::status_type                 status,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [2:0]                           out_kind,
   output logic [7:0]                           out_byte,
   output logic [1:0]                           out_signal,
   output logic                                 out_last
);

   // Configuration registers.
   logic [ctle_pkg::MODE_W-1:0] mode_ff;
   logic [7:0] int_char_ff, quit_char_ff, susp_char_ff;
   logic [7:0] erase_char_ff, kill_char_ff, eof_char_ff;

   // Item state.
   logic [7:0]                 byte_ff, byte_in;
   logic                       last_ff, last_in;
   logic                       aborted_ff, aborted_in;
   logic [ctle_pkg::LEN_W-1:0] len_ff, len_in;
   logic [ctle_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic [7:0]                 store_ff [ctle_pkg::LINE_DEPTH];
   logic [7:0]                 store_rd_ff;

   // Result register.
   logic                      rvalid_ff, rvalid_in;
   ctle_pkg::result_kind_type rkind_ff, rkind_in;
   logic [7:0]                rbyte_ff, rbyte_in;
   logic [1:0]                rsig_ff, rsig_in;
   logic                      rlast_ff, rlast_in;

   logic [1:0] sig_code;
   logic [7:0] letter;
   logic       is_int, is_quit, is_susp;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ctle_pkg::RESET_MODE;
         int_char_ff   <= ctle_pkg::RESET_INTERRUPT;
         quit_char_ff  <= ctle_pkg::RESET_QUIT;
         susp_char_ff  <= ctle_pkg::RESET_SUSPEND;
         erase_char_ff <= ctle_pkg::RESET_ERASE;
         kill_char_ff  <= ctle_pkg::RESET_KILL;
         eof_char_ff   <= ctle_pkg::RESET_EOF;
      end else if (csr_we) begin
         case (csr_index)
            ctle_pkg::REG_MODE:      mode_ff       <= csr_wdata[ctle_pkg::MODE_W-1:0];
            ctle_pkg::REG_INTERRUPT: int_char_ff   <= csr_wdata;
            ctle_pkg::REG_QUIT:      quit_char_ff  <= csr_wdata;
            ctle_pkg::REG_SUSPEND:   susp_char_ff  <= csr_wdata;
            ctle_pkg::REG_ERASE:     erase_char_ff <= csr_wdata;
            ctle_pkg::REG_KILL:      kill_char_ff  <= csr_wdata;
            ctle_pkg::REG_EOF:       eof_char_ff   <= csr_wdata;
            default:                 mode_ff       <= mode_ff;
         endcase
      end
   end

   // Character classification of the held byte.
   assign is_int  = byte_ff == int_char_ff;
   assign is_quit = byte_ff == quit_char_ff;
   assign is_susp = byte_ff == susp_char_ff;
   assign sig_code = is_int  ? ctle_pkg::SIG_INTERRUPT :
                     is_quit ? ctle_pkg::SIG_QUIT : ctle_pkg::SIG_SUSPEND;
   assign letter   = is_int  ? ctle_pkg::CHAR_C :
                     is_quit ? ctle_pkg::CHAR_BSLASH : ctle_pkg::CHAR_Z;

   always_comb begin
      status.out_free = !rvalid_ff || out_ready;
      status.aborted  = aborted_ff;
      status.is_sig   = mode_ff[ctle_pkg::FLAG_SIG] && (is_int || is_quit || is_susp);
      status.canon    = mode_ff[ctle_pkg::FLAG_CANON];
      status.echo     = mode_ff[ctle_pkg::FLAG_ECHO];
      status.echoe    = mode_ff[ctle_pkg::FLAG_ECHOE];
      status.onlcr    = mode_ff[ctle_pkg::FLAG_ONLCR];
      status.is_erase = byte_ff == erase_char_ff;
      status.is_kill  = byte_ff == kill_char_ff;
      status.is_eof   = byte_ff == eof_char_ff;
      status.is_lf    = byte_ff == ctle_pkg::CHAR_LF;
      status.full     = len_ff >= ctle_pkg::LEN_W'(ctle_pkg::LINE_DEPTH);
      status.len_zero = len_ff == '0;
      status.rel_last = ctle_pkg::LEN_W'(idx_ff + 1'b1) == len_ff;
   end

   // Next values of the item state.
   always_comb begin
      byte_in    = byte_ff;
      last_in    = last_ff;
      aborted_in = aborted_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      if (cmd.load) begin
         // The CR to LF map is applied as the byte is taken in.
         byte_in = (mode_ff[ctle_pkg::FLAG_CRNL] && in_byte == ctle_pkg::CHAR_CR)
                   ? ctle_pkg::CHAR_LF : in_byte;
         last_in = in_last;
      end
      if (cmd.set_abort) aborted_in = 1'b1;
      if (cmd.end_item && last_ff) aborted_in = 1'b0;
      if (cmd.clear_len)
         len_in = '0;
      else if (cmd.dec_len)
         len_in = len_ff - 1'b1;
      else if (cmd.store_byte)
         len_in = len_ff + 1'b1;
      if (cmd.idx_clear)
         idx_in = '0;
      else if (cmd.idx_inc)
         idx_in = idx_ff + 1'b1;
   end

   // Next values of the result register.
   always_comb begin
      rvalid_in = rvalid_ff;
      rkind_in  = rkind_ff;
      rbyte_in  = rbyte_ff;
      rsig_in   = rsig_ff;
      rlast_in  = rlast_ff;
      if (cmd.emit) begin
         rvalid_in = 1'b1;
         rkind_in  = cmd.kind;
         rlast_in  = cmd.last;
         rsig_in   = (cmd.kind == ctle_pkg::KIND_SIGNAL) ? sig_code : 2'd0;
         case (cmd.bsel)
            ctle_pkg::BSEL_DATA:   rbyte_in = byte_ff;
            ctle_pkg::BSEL_STORE:  rbyte_in = store_rd_ff;
            ctle_pkg::BSEL_CARET:  rbyte_in = ctle_pkg::CHAR_CARET;
            ctle_pkg::BSEL_LETTER: rbyte_in = letter;
            ctle_pkg::BSEL_CR:     rbyte_in = ctle_pkg::CHAR_CR;
            ctle_pkg::BSEL_LF:     rbyte_in = ctle_pkg::CHAR_LF;
            ctle_pkg::BSEL_BS:     rbyte_in = ctle_pkg::CHAR_BS;
            ctle_pkg::BSEL_SP:     rbyte_in = ctle_pkg::CHAR_SP;
            default:               rbyte_in = 8'd0;
         endcase
      end else if (out_ready) begin
         rvalid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         aborted_ff <= 1'b0;
         len_ff     <= '0;
         idx_ff     <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         aborted_ff <= aborted_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      rkind_ff <= rkind_in;
      rbyte_ff <= rbyte_in;
      rsig_ff  <= rsig_in;
      rlast_ff <= rlast_in;
   end

   // Line store: written at the current length. The read register follows the
   // next release index, so it always holds the entry at the current index; a
   // byte written at the same edge and index is taken over directly.
   always_ff @(posedge clock) begin
      if (cmd.store_byte)
         store_ff[len_ff[ctle_pkg::IDX_W-1:0]] <= byte_ff;
      if (cmd.store_byte &&
          len_ff[ctle_pkg::IDX_W-1:0] == idx_in[ctle_pkg::IDX_W-1:0])
         store_rd_ff <= byte_ff;
      else
         store_rd_ff <= store_ff[idx_in[ctle_pkg::IDX_W-1:0]];
   end

   assign out_valid  = rvalid_ff;
   assign out_kind   = rkind_ff;
   assign out_byte   = rbyte_ff;
   assign out_signal = rsig_ff;
   assign out_last   = rlast_ff;

endmodule

`default_nettype wire

// ----- rtl/core/canonical_tty_line_editor_unit.sv -----
// Top level of the canonical tty line editor: controller, datapath and channel wiring.
`default_nettype none

// Terminal line editor. Each accepted typed byte produces zero or more result
// words, one word per cycle while the result side takes them. An item passes
// through an accept step, a decode step, its result words and a closing step,
// and output stalls lengthen it. The controller emits the words of one item in
// sequence through a single result register, and the line store is read one
// entry per cycle while the result side takes them when a line is released.
// A new byte is taken only once all words of the previous one have been placed
// in the result register. Configuration is to be written through the csr port
// only while idle; the block itself does not enforce this.
module canonical_tty_line_editor_unit (
   input  logic                             clock,
   input  logic                             reset,
   ctle_req_if.sink                         req_chan,
   ctle_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [ctle_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ctle_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ctle_pkg::cmd_type    cmd;
   ctle_pkg::status_type status;
   logic                 in_ready;
   logic [2:0]           out_kind;
   logic [7:0]           out_byte;
   logic [1:0]           out_signal;
   logic                 out_last;
   logic                 out_valid;

   // Sequencing of the result words.
   ctle_ctl u_ctl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // Storage, classification and the result register.
   ctle_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_byte    (req_chan.data_byte),
      .in_last    (req_chan.last_of_write),
      .cmd        (cmd),
      .status     (status),
      .out_valid  (out_valid),
      .out_ready  (rsp_chan.ready),
      .out_kind   (out_kind),
      .out_byte   (out_byte),
      .out_signal (out_signal),
      .out_last   (out_last)
   );

   assign req_chan.ready       = in_ready;
   assign rsp_chan.valid       = out_valid;
   assign rsp_chan.result_kind = out_kind;
   assign rsp_chan.result_byte = out_byte;
   assign rsp_chan.signal_kind = out_signal;
   assign rsp_chan.last_result = out_last;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking testbench of the canonical tty line editor with a result-word scoreboard.
`default_nettype none

module tb;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int DRAIN_CYCLES  = 3 * ctle_pkg::LINE_DEPTH + 12;
   localparam int RUN_LIMIT     = 10_000_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 22;
   localparam int MAX_WAIT      = 11;

   // One expected result word.
   typedef struct {
      ctle_pkg::result_kind_type kind;
      logic [7:0]                rbyte;
      logic [1:0]                sig;
      logic                      last;
   } result_word_type;

   // Line editor predictor and the queue of result words it expects.
   class line_editor_scoreboard;
      logic [ctle_pkg::MODE_W-1:0] mode;
      logic [7:0]        chr_intr, chr_quit, chr_susp, chr_erase, chr_kill, chr_eof;
      logic [7:0]        line_buf [ctle_pkg::LINE_DEPTH];
      int                line_len;
      bit                aborted;
      result_word_type   expected_words [$];
      int                failures;

      function new();
         mode      = ctle_pkg::RESET_MODE;
         chr_intr  = ctle_pkg::RESET_INTERRUPT;
         chr_quit  = ctle_pkg::RESET_QUIT;
         chr_susp  = ctle_pkg::RESET_SUSPEND;
         chr_erase = ctle_pkg::RESET_ERASE;
         chr_kill  = ctle_pkg::RESET_KILL;
         chr_eof   = ctle_pkg::RESET_EOF;
         line_len  = 0;
         aborted   = 1'b0;
         failures  = 0;
      endfunction

      function void write_register(logic [ctle_pkg::CSR_IDX_W-1:0] idx, logic [7:0] value);
         case (idx)
            ctle_pkg::REG_MODE:      mode      = value[ctle_pkg::MODE_W-1:0];
            ctle_pkg::REG_INTERRUPT: chr_intr  = value;
            ctle_pkg::REG_QUIT:      chr_quit  = value;
            ctle_pkg::REG_SUSPEND:   chr_susp  = value;
            ctle_pkg::REG_ERASE:     chr_erase = value;
            ctle_pkg::REG_KILL:      chr_kill  = value;
            ctle_pkg::REG_EOF:       chr_eof   = value;
            default: ;
         endcase
      endfunction

      function void add_word(ctle_pkg::result_kind_type kind, logic [7:0] rbyte,
                             logic [1:0] sig);
         result_word_type w;
         w.kind  = kind;
         w.rbyte = rbyte;
         w.sig   = sig;
         w.last  = 1'b0;
         expected_words.push_back(w);
      endfunction

      // Echo of one byte; a newline gets a carriage return in front under onlcr.
      function void echo_char(logic [7:0] v);
         if (!mode[ctle_pkg::FLAG_ECHO]) return;
         if (v == ctle_pkg::CHAR_LF && mode[ctle_pkg::FLAG_ONLCR])
            add_word(ctle_pkg::KIND_ECHO, ctle_pkg::CHAR_CR, 2'd0);
         add_word(ctle_pkg::KIND_ECHO, v, 2'd0);
      endfunction

      // Removes the last stored byte and, under echo and echoe, rubs it out on the screen.
      function void rub_out();
         if (line_len == 0) return;
         line_len--;
         if (mode[ctle_pkg::FLAG_ECHO] && mode[ctle_pkg::FLAG_ECHOE]) begin
            add_word(ctle_pkg::KIND_ECHO, ctle_pkg::CHAR_BS, 2'd0);
            add_word(ctle_pkg::KIND_ECHO, ctle_pkg::CHAR_SP, 2'd0);
            add_word(ctle_pkg::KIND_ECHO, ctle_pkg::CHAR_BS, 2'd0);
         end
      endfunction

      function void release_line();
         for (int i = 0; i < line_len; i++)
            add_word(ctle_pkg::KIND_DELIVER, line_buf[i], 2'd0);
         line_len = 0;
      endfunction

      // Works out the result words of one accepted typed byte.
      function void predict_words(logic [7:0] data_byte, logic last_of_write);
         logic [7:0]      v;
         logic [1:0]      sig;
         logic [7:0]      letter;
         int              first_count;
         result_word_type w;
         first_count = expected_words.size();
         v = data_byte;
         if (aborted) begin
            add_word(ctle_pkg::KIND_REJECT, 8'd0, 2'd0);
         end else begin
            if (mode[ctle_pkg::FLAG_CRNL] && v == ctle_pkg::CHAR_CR) v = ctle_pkg::CHAR_LF;
            if (mode[ctle_pkg::FLAG_SIG] &&
                (v == chr_intr || v == chr_quit || v == chr_susp)) begin
               // Interrupt wins over quit, and quit over suspend.
               sig = (v == chr_intr) ? ctle_pkg::SIG_INTERRUPT :
                     (v == chr_quit) ? ctle_pkg::SIG_QUIT : ctle_pkg::SIG_SUSPEND;
               letter = (sig == ctle_pkg::SIG_INTERRUPT) ? ctle_pkg::CHAR_C :
                        (sig == ctle_pkg::SIG_QUIT) ? ctle_pkg::CHAR_BSLASH : ctle_pkg::CHAR_Z;
               add_word(ctle_pkg::KIND_SIGNAL, 8'd0, sig);
               add_word(ctle_pkg::KIND_FLUSH, 8'd0, 2'd0);
               line_len = 0;
               if (mode[ctle_pkg::FLAG_ECHO]) begin
                  add_word(ctle_pkg::KIND_ECHO, ctle_pkg::CHAR_CARET, 2'd0);
                  add_word(ctle_pkg::KIND_ECHO, letter, 2'd0);
                  add_word(ctle_pkg::KIND_ECHO, ctle_pkg::CHAR_CR, 2'd0);
                  add_word(ctle_pkg::KIND_ECHO, ctle_pkg::CHAR_LF, 2'd0);
               end
            end else if (!mode[ctle_pkg::FLAG_CANON]) begin
               add_word(ctle_pkg::KIND_DELIVER, v, 2'd0);
               echo_char(v);
            end else if (v == chr_erase) begin
               rub_out();
            end else if (v == chr_kill) begin
               while (line_len > 0) rub_out();
            end else if (v == chr_eof) begin
               if (line_len > 0) release_line();
               else add_word(ctle_pkg::KIND_EOF, 8'd0, 2'd0);
            end else if (line_len >= ctle_pkg::LINE_DEPTH) begin
               // Full line store: the rest of this write is rejected.
               add_word(ctle_pkg::KIND_REJECT, 8'd0, 2'd0);
               aborted = 1'b1;
            end else begin
               line_buf[line_len] = v;
               line_len++;
               echo_char(v);
               if (v == ctle_pkg::CHAR_LF) release_line();
            end
         end
         if (last_of_write) aborted = 1'b0;
         if (expected_words.size() > first_count) begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
         end
      endfunction

      function int pending_count();
         return expected_words.size();
      endfunction

      // Compares one received result word with the oldest expectation.
      function void check_word(logic [2:0] kind, logic [7:0] rbyte, logic [1:0] sig,
                               logic last);
         result_word_type w;
         if (expected_words.size() == 0) begin
            $error("unexpected result word: result_kind %0d result_byte 0x%02h", kind, rbyte);
            failures++;
            return;
         end
         w = expected_words.pop_front();
         if (kind !== w.kind) begin
            $error("result_kind: expected %0d, actual %0d", w.kind, kind);
            failures++;
         end
         if (rbyte !== w.rbyte) begin
            $error("result_byte: expected 0x%02h, actual 0x%02h", w.rbyte, rbyte);
            failures++;
         end
         if (sig !== w.sig) begin
            $error("signal_kind: expected %0d, actual %0d", w.sig, sig);
            failures++;
         end
         if (last !== w.last) begin
            $error("last_result: expected %0d, actual %0d", w.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            csr_we    = 1'b0;
   logic [ctle_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ctle_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   bit                              no_idle   = 1'b0;
   int                              items_sent = 0;

   ctle_req_if req_chan ();
   ctle_rsp_if rsp_chan ();

   line_editor_scoreboard sb = new();

   canonical_tty_line_editor_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Number of idle cycles before the next word on either side.
   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // A byte that the current settings give a meaning to.
   function automatic logic [7:0] control_byte();
      case ($urandom_range(0, 7))
         0:       return sb.chr_intr;
         1:       return sb.chr_quit;
         2:       return sb.chr_susp;
         3:       return sb.chr_erase;
         4:       return sb.chr_kill;
         5:       return sb.chr_eof;
         6:       return ctle_pkg::CHAR_CR;
         default: return ctle_pkg::CHAR_LF;
      endcase
   endfunction

   // Offers one typed byte and waits until the block takes it.
   task automatic send_byte(input logic [7:0] value, input logic last);
      int n;
      n = draw_wait();
      if (n > 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.data_byte     <= value;
      req_chan.last_of_write <= last;
      do @(posedge clock); while (!req_chan.ready);
      sb.predict_words(value, last);
      items_sent++;
   endtask

   // Writes all configuration registers, one per cycle.
   task automatic write_settings(input logic [ctle_pkg::MODE_W-1:0] mode,
                                 input logic [7:0] intr_c,
                                 input logic [7:0] quit_c, input logic [7:0] susp_c,
                                 input logic [7:0] erase_c, input logic [7:0] kill_c,
                                 input logic [7:0] eof_c);
      logic [7:0] values [7];
      values[ctle_pkg::REG_MODE]      = 8'(mode);
      values[ctle_pkg::REG_INTERRUPT] = intr_c;
      values[ctle_pkg::REG_QUIT]      = quit_c;
      values[ctle_pkg::REG_SUSPEND]   = susp_c;
      values[ctle_pkg::REG_ERASE]     = erase_c;
      values[ctle_pkg::REG_KILL]      = kill_c;
      values[ctle_pkg::REG_EOF]       = eof_c;
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= ctle_pkg::CSR_IDX_W'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         sb.write_register(ctle_pkg::CSR_IDX_W'(i), values[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Stops offering bytes and lets the block finish all pending work.
   task automatic end_phase();
      req_chan.valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls before each word.
   initial begin : result_taker
      int n;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Every word taken on the result channel is checked.
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready) begin
         sb.check_word(rsp_chan.result_kind, rsp_chan.result_byte, rsp_chan.signal_kind,
                       rsp_chan.last_result);
      end
   end

   initial begin : stimulus
      int                          target;
      int                          n;
      logic [ctle_pkg::MODE_W-1:0] m;
      logic [7:0]                  b;
      req_chan.valid         <= 1'b0;
      req_chan.data_byte     <= 8'd0;
      req_chan.last_of_write <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_settings(ctle_pkg::RESET_MODE, ctle_pkg::RESET_INTERRUPT, ctle_pkg::RESET_QUIT,
                     ctle_pkg::RESET_SUSPEND, ctle_pkg::RESET_ERASE, ctle_pkg::RESET_KILL,
                     ctle_pkg::RESET_EOF);

      // Directed part at the default settings.
      send_byte(ctle_pkg::RESET_EOF, 1'b1);    // end of file on an empty line
      send_byte(ctle_pkg::RESET_ERASE, 1'b1);  // erase on an empty line gives nothing
      for (int i = 0; i < ctle_pkg::LINE_DEPTH; i++) begin
         b = (i == 0) ? 8'h00 : (i == ctle_pkg::LINE_DEPTH - 1) ? 8'hFF : 8'(8'h40 + i);
         send_byte(b, 1'b0);
      end
      send_byte(8'h6B, 1'b0);        // store full, starts a rejection run
      send_byte(8'h6C, 1'b1);        // still rejected, ends the run
      send_byte(ctle_pkg::RESET_KILL, 1'b1);   // kill of a full line
      send_byte(8'h71, 1'b0);
      send_byte(ctle_pkg::RESET_INTERRUPT, 1'b1);
      send_byte(ctle_pkg::RESET_QUIT, 1'b1);
      send_byte(ctle_pkg::RESET_SUSPEND, 1'b1);
      send_byte(8'h78, 1'b0);
      send_byte(ctle_pkg::RESET_ERASE, 1'b0);
      send_byte(8'h79, 1'b0);
      send_byte(ctle_pkg::CHAR_CR, 1'b1);      // mapped to newline, releases the line
      end_phase();

      // Random part: several settings, mostly whole lines with random content.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: write_settings('0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            1: write_settings('1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            2: write_settings('1, 8'h61, 8'h71, 8'h71, 8'h65, 8'h65, 8'h66);
            default: begin
               m = ctle_pkg::MODE_W'($urandom_range(0, 63));
               if ($urandom_range(0, 3) != 0) m[ctle_pkg::FLAG_CANON] = 1'b1;
               write_settings(m, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
         endcase
         no_idle = (p % 3 == 2);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(0, 3) != 0) begin
               // A typed line, sometimes longer than the store, then a closing byte.
               n = ($urandom_range(0, 3) == 0)
                   ? ctle_pkg::LINE_DEPTH + $urandom_range(0, 3)
                   : $urandom_range(0, ctle_pkg::LINE_DEPTH - 1);
               for (int i = 0; i < n; i++) begin
                  b = ($urandom_range(0, 9) == 0) ? sb.chr_erase : 8'($urandom_range(0, 255));
                  send_byte(b, $urandom_range(0, 3) == 0);
               end
               send_byte(control_byte(), 1'($urandom_range(0, 1)));
            end else begin
               // Short bursts of noise.
               repeat ($urandom_range(1, 4)) begin
                  b = ($urandom_range(0, 1) == 0) ? control_byte() : 8'($urandom_range(0, 255));
                  send_byte(b, 1'($urandom_range(0, 1)));
               end
            end
         end
         end_phase();
      end

      if (sb.failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Guard against a hung block.
   initial begin : watchdog
      #RUN_LIMIT;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
